// File: sv/gcl_pkg.sv
package gcl_pkg;

  // image geometry
  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PTR_W  = ADDR_W + 1;
  localparam int LBL_W  = ADDR_W;
  localparam int QUE_W  = ROW_W + COL_W;

  // fixed port widths
  localparam int POS_W     = 5;
  localparam int OUT_W     = 10;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int ROWS_RESET = 32;
  localparam int COLS_RESET = 32;

  localparam int CMP_A = (RCNT_W > CCNT_W) ? RCNT_W : CCNT_W;
  localparam int CMP_B = (CFG_W > POS_W) ? CFG_W : POS_W;
  localparam int CMP_W = ((CMP_A > CMP_B) ? CMP_A : CMP_B) + 1;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic clr_pix;
    logic wr_pix;
    logic rd_lbl;
    logic run_start;
    logic scan_rd;
    logic new_region;
    logic scan_adv;
    logic pop_rd;
    logic take_cell;
    logic nb_rd;
    logic nb_mark;
    logic dir_adv;
    logic out_lbl;
    logic out_cnt;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic win_empty;
    logic hit;
    logic scan_last;
    logic q_empty;
    logic nb_in;
    logic dir_last;
    logic out_free;
  } sts_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_COLS + int'(c));
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input logic [LBL_W-1:0] v);
    return OUT_W'(v);
  endfunction

endpackage

// File: sv/gcl_ctrl.sv
module gcl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_mode,
  output logic          in_stall,
  input  gcl_pkg::sts_t sts,
  output gcl_pkg::cmd_t cmd
);
  import gcl_pkg::*;

  typedef enum logic [10:0] {
    S_INIT     = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_RDWAIT   = 11'b00000000100,
    S_CLEAR    = 11'b00000001000,
    S_SCAN_RD  = 11'b00000010000,
    S_SCAN_CHK = 11'b00000100000,
    S_POP      = 11'b00001000000,
    S_POP_WAIT = 11'b00010000000,
    S_NB_RD    = 11'b00100000000,
    S_NB_CHK   = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_en  = 1'b1;
        cmd.clr_pix = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_mode)
            MODE_WRITE: cmd.wr_pix = 1'b1;
            MODE_RUN: begin
              cmd.run_start = 1'b1;
              state_nxt     = S_CLEAR;
            end
            MODE_READ: begin
              cmd.rd_lbl = 1'b1;
              state_nxt  = S_RDWAIT;
            end
            default: ;
          endcase
        end
      end
      S_RDWAIT: begin
        if (sts.out_free) begin
          cmd.out_lbl = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = sts.win_empty ? S_DONE : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.hit) begin
          cmd.new_region = 1'b1;
          state_nxt      = S_POP;
        end else if (sts.scan_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_adv = 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end
      S_POP: begin
        if (!sts.q_empty) begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POP_WAIT;
        end else if (sts.scan_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_adv = 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end
      S_POP_WAIT: begin
        cmd.take_cell = 1'b1;
        state_nxt     = S_NB_RD;
      end
      S_NB_RD: begin
        if (sts.nb_in) begin
          cmd.nb_rd = 1'b1;
          state_nxt = S_NB_CHK;
        end else if (sts.dir_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.dir_adv = 1'b1;
        end
      end
      S_NB_CHK: begin
        cmd.nb_mark = sts.hit;
        if (sts.dir_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.dir_adv = 1'b1;
          state_nxt   = S_NB_RD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_cnt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

// File: sv/gcl_dp.sv
module gcl_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gcl_pkg::cmd_t               cmd,
  output gcl_pkg::sts_t               sts,
  input  logic [gcl_pkg::RCNT_W-1:0]  eff_rows,
  input  logic [gcl_pkg::CCNT_W-1:0]  eff_cols,
  input  logic [gcl_pkg::POS_W-1:0]   in_row,
  input  logic [gcl_pkg::POS_W-1:0]   in_col,
  input  logic                        in_pixel,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [gcl_pkg::OUT_W-1:0]   out_label,
  output logic [gcl_pkg::OUT_W-1:0]   out_region_count
);
  import gcl_pkg::*;

  // stores
  logic              pix_mem [CELLS];
  logic [LBL_W-1:0]  lbl_mem [CELLS];
  logic [QUE_W-1:0]  que_mem [CELLS];

  logic              pix_q_r;
  logic [LBL_W-1:0]  lbl_q_r;
  logic [QUE_W-1:0]  que_q_r;

  logic [ADDR_W-1:0] clr_addr_r;
  logic [LBL_W-1:0]  count_r;
  logic [PTR_W-1:0]  head_r, tail_r;
  logic [ROW_W-1:0]  sr_r, cur_r_r;
  logic [COL_W-1:0]  sc_r, cur_c_r;
  dir_t              dir_r;
  logic              rd_inside_r;

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_label_r, out_count_r;

  logic              in_inside;
  logic [ADDR_W-1:0] in_addr, scan_addr, nb_addr;
  logic [ROW_W-1:0]  nb_r;
  logic [COL_W-1:0]  nb_c;
  logic              nb_in;
  logic              scan_col_last, scan_row_last;
  logic              out_free;

  logic              pix_we, pix_wd, pix_re;
  logic [ADDR_W-1:0] pix_wa, pix_ra;
  logic              lbl_we, lbl_re;
  logic [ADDR_W-1:0] lbl_wa, lbl_ra;
  logic [LBL_W-1:0]  lbl_wd;
  logic              que_we;
  logic [QUE_W-1:0]  que_wd;

  assign in_inside = (CMP_W'(in_row) < CMP_W'(eff_rows)) &&
                     (CMP_W'(in_col) < CMP_W'(eff_cols));
  assign in_addr   = cell_addr(ROW_W'(in_row), COL_W'(in_col));
  assign scan_addr = cell_addr(sr_r, sc_r);
  assign nb_addr   = cell_addr(nb_r, nb_c);

  // neighbor in the current direction and whether it lies in the window
  always_comb begin
    nb_r  = cur_r_r;
    nb_c  = cur_c_r;
    nb_in = 1'b0;
    case (dir_r)
      DIR_DOWN: begin
        nb_r  = cur_r_r + ROW_W'(1);
        nb_in = (RCNT_W'(cur_r_r) + RCNT_W'(1)) < eff_rows;
      end
      DIR_RIGHT: begin
        nb_c  = cur_c_r + COL_W'(1);
        nb_in = (CCNT_W'(cur_c_r) + CCNT_W'(1)) < eff_cols;
      end
      DIR_UP: begin
        nb_r  = cur_r_r - ROW_W'(1);
        nb_in = cur_r_r != '0;
      end
      DIR_LEFT: begin
        nb_c  = cur_c_r - COL_W'(1);
        nb_in = cur_c_r != '0;
      end
      default: nb_in = 1'b0;
    endcase
  end

  assign scan_col_last = (CCNT_W'(sc_r) + CCNT_W'(1)) == eff_cols;
  assign scan_row_last = (RCNT_W'(sr_r) + RCNT_W'(1)) == eff_rows;
  assign out_free      = !out_valid_r || !out_stall;

  always_comb begin
    sts.clr_last  = clr_addr_r == ADDR_W'(CELLS - 1);
    sts.win_empty = (eff_rows == '0) || (eff_cols == '0);
    sts.hit       = pix_q_r && (lbl_q_r == '0);
    sts.scan_last = scan_row_last && scan_col_last;
    sts.q_empty   = head_r == tail_r;
    sts.nb_in     = nb_in;
    sts.dir_last  = dir_r == DIR_LEFT;
    sts.out_free  = out_free;
  end

  // store port muxes
  always_comb begin
    pix_we = (cmd.clr_en && cmd.clr_pix) || (cmd.wr_pix && in_inside);
    pix_wa = cmd.clr_en ? clr_addr_r : in_addr;
    pix_wd = cmd.clr_en ? 1'b0 : in_pixel;
    pix_re = cmd.scan_rd || cmd.nb_rd;
    pix_ra = cmd.nb_rd ? nb_addr : scan_addr;

    lbl_we = cmd.clr_en || cmd.new_region || cmd.nb_mark;
    lbl_wa = cmd.clr_en ? clr_addr_r : (cmd.nb_mark ? nb_addr : scan_addr);
    lbl_wd = cmd.clr_en ? '0 : (cmd.nb_mark ? count_r : count_r + LBL_W'(1));
    lbl_re = cmd.scan_rd || cmd.nb_rd || cmd.rd_lbl;
    lbl_ra = cmd.rd_lbl ? in_addr : (cmd.nb_rd ? nb_addr : scan_addr);

    que_we = cmd.new_region || cmd.nb_mark;
    que_wd = cmd.nb_mark ? {nb_r, nb_c} : {sr_r, sc_r};
  end

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[pix_wa] <= pix_wd;
    if (pix_re) pix_q_r <= pix_mem[pix_ra];
  end

  always_ff @(posedge clk) begin
    if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
    if (lbl_re) lbl_q_r <= lbl_mem[lbl_ra];
  end

  always_ff @(posedge clk) begin
    if (que_we) que_mem[tail_r[ADDR_W-1:0]] <= que_wd;
    if (cmd.pop_rd) que_q_r <= que_mem[head_r[ADDR_W-1:0]];
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) begin
        clr_addr_r <= sts.clr_last ? '0 : clr_addr_r + ADDR_W'(1);
      end
      if (cmd.run_start) begin
        count_r <= '0;
        head_r  <= '0;
        tail_r  <= '0;
      end else begin
        if (cmd.new_region) count_r <= count_r + LBL_W'(1);
        if (que_we) tail_r <= tail_r + PTR_W'(1);
        if (cmd.pop_rd) head_r <= head_r + PTR_W'(1);
      end
      if (cmd.out_lbl || cmd.out_cnt) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan position, current cell, result payload
  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      sr_r <= '0;
      sc_r <= '0;
    end else if (cmd.scan_adv) begin
      if (scan_col_last) begin
        sc_r <= '0;
        sr_r <= sr_r + ROW_W'(1);
      end else begin
        sc_r <= sc_r + COL_W'(1);
      end
    end
    if (cmd.take_cell) begin
      {cur_r_r, cur_c_r} <= que_q_r;
      dir_r              <= DIR_DOWN;
    end else if (cmd.dir_adv) begin
      dir_r <= dir_t'(dir_r + 2'd1);
    end
    if (cmd.rd_lbl) rd_inside_r <= in_inside;
    if (cmd.out_lbl) begin
      out_label_r <= rd_inside_r ? to_out(lbl_q_r) : '0;
      out_count_r <= to_out(count_r);
    end else if (cmd.out_cnt) begin
      out_label_r <= '0;
      out_count_r <= to_out(count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_label        = out_label_r;
  assign out_region_count = out_count_r;

endmodule

// File: sv/grid_component_labeler.sv
// 4-connected component labeler over a MAX_ROWS x MAX_COLS one-bit image
//
// input channel (in_valid / in_stall): one beat per command
//   write pixel: stores in_pixel at in_row, in_col inside the window, no result
//   run: clears the label store and labels the window, one result beat
//     with region_count and label 0
//   read label: one result beat, label 0
//     outside the window, region_count from the last run
// result channel (out_valid / out_stall): one output register; a read or a
//   run may be accepted while an earlier result still waits there
// run steps: a clearing pass over all 1024 label cells, a raster scan of
//   the window pixels, and per flooded pixel a queue read plus a read of
//   each neighbor inside the window; each store has a single read port
// config (cfg_we / cfg_index / cfg_wdata) also acts on a run in progress
// reset: a clearing pass over all 1024 cells zeroes the pixel and label
//   stores, in_stall stays high until it ends
// a stalled result holds; the block then waits for the slot before the
//   next read or run completes
module grid_component_labeler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic [gcl_pkg::POS_W-1:0]      in_row,
  input  logic [gcl_pkg::POS_W-1:0]      in_col,
  input  logic                           in_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gcl_pkg::OUT_W-1:0]      out_label,
  output logic [gcl_pkg::OUT_W-1:0]      out_region_count,
  input  logic                           cfg_we,
  input  logic [gcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gcl_pkg::CFG_W-1:0]      cfg_wdata
);
  import gcl_pkg::*;

  logic [CFG_W-1:0]  rows_in_use_r, cols_in_use_r;
  logic [RCNT_W-1:0] eff_rows;
  logic [CCNT_W-1:0] eff_cols;
  cmd_t              cmd;
  sts_t              sts;

  // window size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= CFG_W'(ROWS_RESET);
      cols_in_use_r <= CFG_W'(COLS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: rows_in_use_r <= cfg_wdata;
        REG_COLS: cols_in_use_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // oversized window saturates to the store size
  assign eff_rows = (int'(rows_in_use_r) > MAX_ROWS) ? RCNT_W'(MAX_ROWS)
                                                     : RCNT_W'(rows_in_use_r);
  assign eff_cols = (int'(cols_in_use_r) > MAX_COLS) ? CCNT_W'(MAX_COLS)
                                                     : CCNT_W'(cols_in_use_r);

  gcl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gcl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .eff_rows         (eff_rows),
    .eff_cols         (eff_cols),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_pixel         (in_pixel),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_label        (out_label),
    .out_region_count (out_region_count)
  );

  // reset always starts the clearing pass
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken right after reset");

  // a run holds off further commands
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_mode == MODE_RUN) |=> in_stall)
    else $error("command taken during a run");

  // no label beyond the number of regions found
  a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_label <= out_region_count))
    else $error("label exceeds region count");

endmodule

// File: verif/tb_grid_component_labeler.sv
`timescale 1ns / 100ps

module tb_grid_component_labeler;
  import gcl_pkg::*;

  // run shape
  localparam int PHASE_ITEMS = 240;
  localparam int SETTLE      = 8;
  localparam int LIMIT       = 3_000_000;
  localparam int MAX_REPORTS = 40;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // one input beat: command plus position and pixel value
  typedef struct packed {
    logic [1:0]       mode;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             pixel;
  } px_cmd_t;

  // one result beat as the labeler should produce it
  typedef struct packed {
    logic [OUT_W-1:0] label;
    logic [OUT_W-1:0] count;
  } label_reply_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_mode = MODE_WRITE;
  logic [POS_W-1:0]     in_row = '0;
  logic [POS_W-1:0]     in_col = '0;
  logic                 in_pixel = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_W-1:0]     out_label;
  logic [OUT_W-1:0]     out_region_count;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  grid_component_labeler uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_label        (out_label),
    .out_region_count (out_region_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // stimulus backlog and the replies still owed by the labeler
  px_cmd_t      cmd_backlog[$];
  label_reply_t reply_fifo[$];
  px_cmd_t      cur_cmd;

  // shadow image, labels and window registers
  logic             img_bits[CELLS];
  logic [OUT_W-1:0] img_labels[CELLS];
  int               flood_fifo[CELLS];
  logic [OUT_W-1:0] last_regions = '0;
  logic [CFG_W-1:0] rows_cfg = CFG_W'(ROWS_RESET);
  logic [CFG_W-1:0] cols_cfg = CFG_W'(COLS_RESET);

  // idling percentages, changed per phase
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  // bookkeeping
  int n_queued = 0;
  int n_writes = 0;
  int n_runs = 0;
  int n_reads = 0;
  int n_ignored = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_windows = 0;
  int most_regions = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // window size as the labeler sees it: values above the maximum saturate
  function automatic int clip_dim(input logic [CFG_W-1:0] v, input int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  // raster scan with breadth-first flood, down / right / up / left
  function automatic int flood_label_all(input int nr, input int nc);
    int found, head, tail, here, r, c, rr, cc, nxt, d, pos;
    found = 0;
    for (pos = 0; pos < CELLS; pos++) img_labels[pos] = '0;
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        pos = r * MAX_COLS + c;
        if (img_bits[pos] && img_labels[pos] == '0) begin
          found++;
          head = 0;
          tail = 1;
          flood_fifo[0] = pos;
          img_labels[pos] = OUT_W'(found);
          while (head < tail) begin
            here = flood_fifo[head];
            head++;
            for (d = 0; d < 4; d++) begin
              rr = here / MAX_COLS;
              cc = here % MAX_COLS;
              case (dir_t'(d))
                DIR_DOWN:  rr++;
                DIR_RIGHT: cc++;
                DIR_UP:    rr--;
                DIR_LEFT:  cc--;
              endcase
              if (rr >= 0 && rr < nr && cc >= 0 && cc < nc) begin
                nxt = rr * MAX_COLS + cc;
                if (img_bits[nxt] && img_labels[nxt] == '0 && tail < CELLS) begin
                  flood_fifo[tail] = nxt;
                  tail++;
                  img_labels[nxt] = OUT_W'(found);
                end
              end
            end
          end
        end
      end
    end
    return found;
  endfunction

  // update the shadow state for one accepted beat and record what it owes
  function automatic void apply_cmd(input px_cmd_t c);
    int nr, nc, pos, found;
    bit in_win;
    label_reply_t rep;
    nr = clip_dim(rows_cfg, MAX_ROWS);
    nc = clip_dim(cols_cfg, MAX_COLS);
    in_win = int'(c.row) < nr && int'(c.col) < nc;
    pos = int'(c.row) * MAX_COLS + int'(c.col);
    case (c.mode)
      MODE_WRITE: begin
        // writes outside the window are dropped
        if (in_win) img_bits[pos] = c.pixel;
        n_writes++;
      end
      MODE_RUN: begin
        found = flood_label_all(nr, nc);
        if (found > most_regions) most_regions = found;
        last_regions = OUT_W'(found);
        rep.label = '0;
        rep.count = last_regions;
        reply_fifo.insert(reply_fifo.size(), rep);
        n_runs++;
      end
      MODE_READ: begin
        // labels are whatever the last run left, window checked now
        rep.label = in_win ? img_labels[pos] : '0;
        rep.count = last_regions;
        reply_fifo.insert(reply_fifo.size(), rep);
        n_reads++;
      end
      default: n_ignored++;  // unused mode, no result
    endcase
  endfunction

  // driver: one beat held until taken, random gaps between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_cmd(cur_cmd);
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          cur_cmd = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          in_mode  <= cur_cmd.mode;
          in_row   <= cur_cmd.row;
          in_col   <= cur_cmd.col;
          in_pixel <= cur_cmd.pixel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, each taken beat checked field by field
  always @(posedge clk) begin
    label_reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_fifo.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: unexpected result beat label %0d count %0d",
                     $time, out_label, out_region_count);
        end else begin
          want = reply_fifo.pop_front();
          n_checked++;
          if (out_label !== want.label) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: label expected %0d actual %0d",
                       $time, want.label, out_label);
          end
          if (out_region_count !== want.count) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: region_count expected %0d actual %0d",
                       $time, want.count, out_region_count);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding",
               cycles, reply_fifo.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [1:0] mode, input logic [POS_W-1:0] row,
                           input logic [POS_W-1:0] col, input logic pixel);
    px_cmd_t c;
    c.mode  = mode;
    c.row   = row;
    c.col   = col;
    c.pixel = pixel;
    cmd_backlog.insert(cmd_backlog.size(), c);
    if (mode != MODE_UNUSED) n_queued++;
  endtask

  // hold the sender until every beat is out and every reply is back
  task automatic wait_quiet();
    while (cmd_backlog.size() != 0 || in_valid || reply_fifo.size() != 0)
      @(negedge clk);
  endtask

  // window registers only change while the labeler is idle
  task automatic set_window(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    wait_quiet();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_wdata <= rows;
    rows_cfg = rows;
    @(posedge clk);
    cfg_index <= REG_COLS;
    cfg_wdata <= cols;
    cols_cfg = cols;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_windows++;
  endtask

  // mostly small windows, sometimes empty, full or saturating
  function automatic logic [CFG_W-1:0] pick_dim();
    int k;
    k = $urandom_range(19);
    case (k)
      0:       return '0;
      1:       return CFG_W'(32);
      2:       return CFG_W'($urandom_range(63, 33));
      3:       return '1;
      default: return CFG_W'($urandom_range(8, 1));
    endcase
  endfunction

  task automatic pick_pos(input int nr, input int nc, input bit stay_in,
                          output logic [POS_W-1:0] r, output logic [POS_W-1:0] c);
    if (stay_in && nr > 0 && nc > 0) begin
      r = POS_W'($urandom_range(nr - 1, 0));
      c = POS_W'($urandom_range(nc - 1, 0));
    end else begin
      r = POS_W'($urandom_range(31));
      c = POS_W'($urandom_range(31));
    end
  endtask

  // one image: fill, label, probe, disturb, probe stale labels, label again
  task automatic image_round(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                             input bit drain_mid);
    int nr, nc, dens, r, c;
    logic [POS_W-1:0] pr, pc;
    set_window(rows, cols);
    nr = clip_dim(rows, MAX_ROWS);
    nc = clip_dim(cols, MAX_COLS);
    dens = $urandom_range(85, 15);
    if (nr * nc <= 64) begin
      // small window: rewrite every pixel
      for (r = 0; r < nr; r++)
        for (c = 0; c < nc; c++)
          queue_cmd(MODE_WRITE, POS_W'(r), POS_W'(c), $urandom_range(99) < dens);
    end else begin
      // large window: sparse changes on top of whatever is stored
      repeat (48) begin
        pick_pos(nr, nc, 1'b1, pr, pc);
        queue_cmd(MODE_WRITE, pr, pc, $urandom_range(99) < dens);
      end
    end
    // stray writes, often outside the window
    repeat (3) begin
      pick_pos(nr, nc, 1'b0, pr, pc);
      queue_cmd(MODE_WRITE, pr, pc, 1'($urandom_range(1)));
    end
    queue_cmd(MODE_RUN, POS_W'($urandom_range(31)), POS_W'($urandom_range(31)),
              1'($urandom_range(1)));
    repeat (8) begin
      pick_pos(nr, nc, $urandom_range(99) < 60, pr, pc);
      queue_cmd(MODE_READ, pr, pc, 1'($urandom_range(1)));
    end
    if (drain_mid) wait_quiet();
    repeat (4) begin
      pick_pos(nr, nc, 1'b1, pr, pc);
      if ($urandom_range(9) == 0)
        queue_cmd(MODE_UNUSED, pr, pc, 1'($urandom_range(1)));
      else
        queue_cmd(MODE_WRITE, pr, pc, 1'($urandom_range(1)));
    end
    repeat (3) begin
      pick_pos(nr, nc, 1'b1, pr, pc);
      queue_cmd(MODE_READ, pr, pc, 1'($urandom_range(1)));
    end
    queue_cmd(MODE_RUN, POS_W'($urandom_range(31)), POS_W'($urandom_range(31)),
              1'($urandom_range(1)));
    repeat (6) begin
      pick_pos(nr, nc, $urandom_range(99) < 60, pr, pc);
      queue_cmd(MODE_READ, pr, pc, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int ph, phase_base;
    bit first;
    for (int i = 0; i < CELLS; i++) begin
      img_bits[i] = 1'b0;
      img_labels[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 19;
    recv_stall_pct = 68;

    // directed: read before any run, corners, an ignored command
    queue_cmd(MODE_READ, 5'd0, 5'd0, 1'b0);
    queue_cmd(MODE_WRITE, 5'd0, 5'd0, 1'b1);
    queue_cmd(MODE_WRITE, 5'd0, 5'd1, 1'b1);
    queue_cmd(MODE_WRITE, 5'd1, 5'd0, 1'b1);
    queue_cmd(MODE_WRITE, 5'd31, 5'd31, 1'b1);
    queue_cmd(MODE_WRITE, 5'd31, 5'd30, 1'b1);
    queue_cmd(MODE_WRITE, 5'd5, 5'd5, 1'b1);
    queue_cmd(MODE_UNUSED, 5'd5, 5'd6, 1'b1);
    queue_cmd(MODE_RUN, 5'd31, 5'd31, 1'b1);
    queue_cmd(MODE_READ, 5'd1, 5'd0, 1'b0);
    queue_cmd(MODE_READ, 5'd31, 5'd31, 1'b1);
    queue_cmd(MODE_READ, 5'd5, 5'd6, 1'b0);
    // clear a pixel, its label stays until the next run
    queue_cmd(MODE_WRITE, 5'd5, 5'd5, 1'b0);
    queue_cmd(MODE_READ, 5'd5, 5'd5, 1'b0);

    // empty window: run finds nothing, reads give 0, writes dropped
    set_window('0, CFG_W'(32));
    queue_cmd(MODE_WRITE, 5'd2, 5'd2, 1'b1);
    queue_cmd(MODE_RUN, 5'd0, 5'd0, 1'b0);
    queue_cmd(MODE_READ, 5'd0, 5'd0, 1'b0);

    // oversized rows saturate, single column, outside reads
    set_window('1, CFG_W'(1));
    queue_cmd(MODE_RUN, 5'd0, 5'd0, 1'b0);
    queue_cmd(MODE_READ, 5'd31, 5'd0, 1'b0);
    queue_cmd(MODE_READ, 5'd0, 5'd0, 1'b0);
    queue_cmd(MODE_READ, 5'd0, 5'd1, 1'b0);

    // full window again, outside pixels from before rejoin
    set_window(CFG_W'(32), CFG_W'(33));
    queue_cmd(MODE_RUN, 5'd0, 5'd0, 1'b0);
    queue_cmd(MODE_READ, 5'd31, 5'd30, 1'b0);

    // random images, three idling patterns
    for (ph = 0; ph < 3; ph++) begin
      wait_quiet();
      case (ph)
        0: begin
          send_gap_pct = 19;
          recv_stall_pct = 68;
        end
        1: begin
          send_gap_pct = 68;
          recv_stall_pct = 19;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_base = n_queued;
      first = 1'b1;
      while (n_queued - phase_base < PHASE_ITEMS) begin
        image_round(pick_dim(), pick_dim(), first);
        first = 1'b0;
      end
    end

    wait_quiet();
    repeat (SETTLE * 4) @(posedge clk);

    $display("covered %0d pixel writes, %0d labeling runs, %0d label reads, %0d ignored",
             n_writes, n_runs, n_reads, n_ignored);
    $display("%0d window settings, %0d result beats checked, up to %0d regions",
             n_windows, n_checked, most_regions);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
